### hdl/lpc_pkg.sv
// shared types, parameters and codes of the line printer canonicalizer
`default_nettype none
package lpc_pkg;

   localparam int CNT_W = 8;
   localparam int MAX_RES = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // character codes
   localparam logic [7:0] CH_ENQ = 8'o005;
   localparam logic [7:0] CH_BEL = 8'o007;
   localparam logic [7:0] CH_BS  = 8'o010;
   localparam logic [7:0] CH_HT  = 8'o011;
   localparam logic [7:0] CH_LF  = 8'o012;
   localparam logic [7:0] CH_FF  = 8'o014;
   localparam logic [7:0] CH_CR  = 8'o015;
   localparam logic [7:0] CH_SP  = 8'o040;
   localparam logic [7:0] PLOT_BIAS = 8'o100;

   // register indexes
   localparam logic [2:0] REG_FF_CAPABLE  = 3'd0;
   localparam logic [2:0] REG_INDENT_EN   = 3'd1;
   localparam logic [2:0] REG_CAN_BS      = 3'd2;
   localparam logic [2:0] REG_PLOT_ALLOW  = 3'd3;
   localparam logic [2:0] REG_PAGE_LENGTH = 3'd4;
   localparam logic [2:0] REG_PAGE_WIDTH  = 3'd5;
   localparam logic [2:0] REG_INDENT_COLS = 3'd6;

   typedef struct packed {
      logic [2:0]                 cnt;
      logic [MAX_RES-1:0][7:0]    code;
      logic [MAX_RES-1:0][7:0]    rep;
   } entry_type;

endpackage
`default_nettype wire

### hdl/lpc_front.sv
// front end: configuration registers, position state and result classification
`default_nettype none
module lpc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire logic [7:0]          item_char,
   input  wire logic                csr_valid,
   input  wire logic [2:0]          csr_index,
   input  wire logic [7:0]          csr_data,
   output logic                     q_push,
   output lpc_pkg::entry_type       q_entry
);

   localparam int W = lpc_pkg::CNT_W;

   logic         ff_cap_ff, indent_en_ff, can_bs_ff, plot_allow_ff;
   logic [7:0]   page_len_ff, page_wid_ff, indent_cols_ff;

   logic [W-1:0] lc_ff, pc_ff, ll_ff, pl_ff;
   logic         plot_ff, elong_ff, lost_ff;

   logic [W-1:0] lc_in, pc_in, ll_in, pl_in;
   logic         plot_in, elong_in, lost_in;

   logic [2:0]   n;
   logic [W:0]   tab_sum;
   logic [7:0]   pch;
   logic         map_en;
   lpc_pkg::entry_type ent;

   function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
      return (v == lpc_pkg::CNT_MAX) ? v : v + W'(1);
   endfunction

   function automatic logic [7:0] clamp_rep(input logic [W-1:0] v);
      return (v > W'(8'hff)) ? 8'hff : v[7:0];
   endfunction

   function automatic logic [7:0] plot_map(input logic [7:0] c);
      logic [7:0] r;
      r = lpc_pkg::PLOT_BIAS;
      for (int i = 0; i < 6; i++) begin
         r[5-i] = c[i];
      end
      return r;
   endfunction

   always_comb begin
      lc_in = lc_ff;
      pc_in = pc_ff;
      ll_in = ll_ff;
      pl_in = pl_ff;
      plot_in = plot_ff;
      elong_in = elong_ff;
      lost_in = lost_ff;
      n = 3'd0;
      ent = '0;
      pch = item_char;
      tab_sum = '0;
      map_en = 1'b0;
      if (plot_ff) begin
         if (item_char == lpc_pkg::CH_LF) begin
            plot_in = 1'b0;
         end
         map_en = (item_char != lpc_pkg::CH_LF);
         ent.code[0] = item_char;
         ent.rep[0] = 8'd1;
         n = 3'd1;
      end else begin
         case (item_char)
            lpc_pkg::CH_HT: begin
               tab_sum = ({1'b0, lc_ff} + (W+1)'(8)) & ~(W+1)'(7);
               lc_in = tab_sum[W] ? lpc_pkg::CNT_MAX : tab_sum[W-1:0];
            end
            lpc_pkg::CH_LF, lpc_pkg::CH_FF: begin
               if (item_char == lpc_pkg::CH_FF) begin
                  ll_in = (page_len_ff == 8'd0) ? '0 : W'(page_len_ff - 8'd1);
               end
               if (pc_ff != '0) begin
                  ent.code[n[1:0]] = lpc_pkg::CH_CR;
                  ent.rep[n[1:0]] = 8'd1;
                  n = n + 3'd1;
                  ent.code[n[1:0]] = lpc_pkg::CH_LF;
                  ent.rep[n[1:0]] = 8'd1;
                  n = n + 3'd1;
                  pc_in = '0;
                  pl_in = sat_inc(pl_in);
                  if (elong_ff) begin
                     pl_in = sat_inc(pl_in);
                  end
               end
               ll_in = sat_inc(ll_in);
               if (elong_ff) begin
                  ll_in = sat_inc(ll_in);
               end
               plot_in = 1'b0;
               elong_in = 1'b0;
               if (ll_in >= W'(page_len_ff)) begin
                  if ((pl_in != '0 || lost_ff) && ll_in > pl_in) begin
                     if (ff_cap_ff) begin
                        ent.code[n[1:0]] = lpc_pkg::CH_FF;
                        ent.rep[n[1:0]] = 8'd1;
                     end else begin
                        ent.code[n[1:0]] = lpc_pkg::CH_LF;
                        ent.rep[n[1:0]] = clamp_rep(ll_in - pl_in);
                     end
                     n = n + 3'd1;
                     lost_in = 1'b0;
                  end
                  pl_in = '0;
                  ll_in = '0;
               end
               lc_in = indent_en_ff ? W'(indent_cols_ff) : '0;
            end
            lpc_pkg::CH_CR: begin
               lc_in = indent_en_ff ? W'(indent_cols_ff) : '0;
            end
            lpc_pkg::CH_BS: begin
               if (lc_ff != '0) begin
                  lc_in = lc_ff - W'(1);
                  if (can_bs_ff && pc_ff != '0 && lc_in == pc_ff - W'(1)) begin
                     pc_in = pc_ff - W'(1);
                     ent.code[0] = lpc_pkg::CH_BS;
                     ent.rep[0] = 8'd1;
                     n = 3'd1;
                  end
               end
            end
            lpc_pkg::CH_SP: begin
               lc_in = sat_inc(lc_ff);
            end
            default: begin
               if (item_char == lpc_pkg::CH_ENQ && plot_allow_ff) begin
                  plot_in = 1'b1;
                  lost_in = 1'b1;
                  map_en = 1'b1;
               end
               if (item_char == lpc_pkg::CH_BEL && plot_allow_ff) begin
                  elong_in = 1'b1;
                  pch = lpc_pkg::CH_BS;
               end
               if (lc_ff < pc_ff) begin
                  ent.code[n[1:0]] = lpc_pkg::CH_CR;
                  ent.rep[n[1:0]] = 8'd1;
                  n = n + 3'd1;
                  pc_in = '0;
               end
               if (ll_ff > pl_ff) begin
                  ent.code[n[1:0]] = lpc_pkg::CH_LF;
                  ent.rep[n[1:0]] = clamp_rep(ll_ff - pl_ff);
                  n = n + 3'd1;
                  pl_in = ll_ff;
               end
               if (lc_ff < W'(page_wid_ff)) begin
                  if (lc_ff > pc_in) begin
                     ent.code[n[1:0]] = lpc_pkg::CH_SP;
                     ent.rep[n[1:0]] = clamp_rep(lc_ff - pc_in);
                     n = n + 3'd1;
                     pc_in = lc_ff;
                  end
                  ent.code[n[1:0]] = pch;
                  ent.rep[n[1:0]] = 8'd1;
                  n = n + 3'd1;
                  if (pch >= lpc_pkg::CH_SP) begin
                     pc_in = sat_inc(pc_in);
                  end
               end
               if (pch >= lpc_pkg::CH_SP) begin
                  lc_in = sat_inc(lc_ff);
               end
            end
         endcase
      end
      if (map_en) begin
         for (int i = 0; i < lpc_pkg::MAX_RES; i++) begin
            ent.code[i] = plot_map(ent.code[i]);
         end
      end
      ent.cnt = n;
   end

   assign q_push  = item_valid && (n != 3'd0);
   assign q_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_cap_ff <= 1'b1;
         indent_en_ff <= 1'b0;
         can_bs_ff <= 1'b0;
         plot_allow_ff <= 1'b1;
         page_len_ff <= 8'd66;
         page_wid_ff <= 8'd132;
         indent_cols_ff <= 8'd8;
      end else if (csr_valid) begin
         case (csr_index)
            lpc_pkg::REG_FF_CAPABLE:  ff_cap_ff <= csr_data[0];
            lpc_pkg::REG_INDENT_EN:   indent_en_ff <= csr_data[0];
            lpc_pkg::REG_CAN_BS:      can_bs_ff <= csr_data[0];
            lpc_pkg::REG_PLOT_ALLOW:  plot_allow_ff <= csr_data[0];
            lpc_pkg::REG_PAGE_LENGTH: page_len_ff <= csr_data;
            lpc_pkg::REG_PAGE_WIDTH:  page_wid_ff <= csr_data;
            lpc_pkg::REG_INDENT_COLS: indent_cols_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff <= '0;
         pc_ff <= '0;
         ll_ff <= '0;
         pl_ff <= '0;
         plot_ff <= 1'b0;
         elong_ff <= 1'b0;
         lost_ff <= 1'b0;
      end else if (item_valid) begin
         lc_ff <= lc_in;
         pc_ff <= pc_in;
         ll_ff <= ll_in;
         pl_ff <= pl_in;
         plot_ff <= plot_in;
         elong_ff <= elong_in;
         lost_ff <= lost_in;
      end
   end

endmodule
`default_nettype wire

### hdl/lpc_queue.sv
// two-entry queue of classified result groups between front and back
`default_nettype none
module lpc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_push,
   input  wire lpc_pkg::entry_type  q_entry,
   input  wire logic                q_pop,
   output logic                     q_full,
   output logic                     q_nonempty,
   output lpc_pkg::entry_type       q_head
);

   lpc_pkg::entry_type mem_ff [lpc_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign q_full     = (count_ff == 2'(lpc_pkg::QUEUE_DEPTH));
   assign q_nonempty = (count_ff != 2'd0);
   assign q_head     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ptr_ff] <= q_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (q_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (q_push && !q_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (q_pop && !q_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

### hdl/lpc_back.sv
// back end: walks each result group and drives the output register
`default_nettype none
module lpc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_nonempty,
   input  wire lpc_pkg::entry_type  q_head,
   output logic                     q_pop,
   input  wire logic                pop,
   output logic                     empty,
   output logic [7:0]               out_char,
   output logic [7:0]               repeat_count,
   output logic                     last_of_run
);

   logic       out_valid_ff, out_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] char_ff, rep_ff;
   logic       last_ff, last_in;
   logic       load;

   always_comb begin
      load = q_nonempty && (!out_valid_ff || pop);
      last_in = ({1'b0, idx_ff} == (q_head.cnt - 3'd1));
      q_pop = load && last_in;
      idx_in = idx_ff;
      if (load) begin
         idx_in = last_in ? 2'd0 : idx_ff + 2'd1;
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= q_head.code[idx_ff];
         rep_ff <= q_head.rep[idx_ff];
         last_ff <= last_in;
      end
   end

   assign empty        = !out_valid_ff;
   assign out_char     = char_ff;
   assign repeat_count = rep_ff;
   assign last_of_run  = last_ff;

endmodule
`default_nettype wire

### hdl/line_printer_canonicalizer.sv
// top level of the line printer canonicalizer
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+----------------------------------------
//   request  | push in, full out            | req_in_char
//   response | empty out, pop in            | rsp_out_char, rsp_repeat_count,
//            |                              | rsp_last_of_run
//   csr      | csr_valid in, csr_ready out  | csr_index, csr_data
//
// a character is classified in the cycle it is taken and yields zero to four results
// results leave one per cycle from the output register while pop takes them, and
// new characters are taken while earlier result groups still wait, unless full is high
// full rises when both entries of the two-entry result-group queue are occupied
// reset is synchronous; csr writes are always taken
`default_nettype none
module line_printer_canonicalizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_in_char,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_char,
   output logic [7:0]       rsp_repeat_count,
   output logic             rsp_last_of_run,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   logic               item_valid;
   logic               q_push, q_pop, q_full, q_nonempty;
   lpc_pkg::entry_type q_entry, q_head;

   assign csr_ready  = 1'b1;
   assign full       = q_full;
   assign item_valid = push && !q_full;

   lpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_char  (req_in_char),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   lpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_push     (q_push),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .q_full     (q_full),
      .q_nonempty (q_nonempty),
      .q_head     (q_head)
   );

   lpc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_nonempty   (q_nonempty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .out_char     (rsp_out_char),
      .repeat_count (rsp_repeat_count),
      .last_of_run  (rsp_last_of_run)
   );

endmodule
`default_nettype wire

### hdl/lpc_checker.sv
// port-level checks of the line printer canonicalizer and their binding
`default_nettype none
module lpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [7:0]  rsp_out_char,
   input wire logic [7:0]  rsp_repeat_count,
   input wire logic        rsp_last_of_run
);

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("not idle after reset");

   // a full queue always has a result presented next cycle
   a_full_drains: assert property (@(posedge clock) disable iff (reset)
      full |=> !empty)
      else $error("queue full but no result shown");

   // a result that is not taken holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_char)
                            && $stable(rsp_repeat_count) && $stable(rsp_last_of_run)))
      else $error("stalled result changed");

   // every run sends at least one code
   a_rep_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_repeat_count != 8'd0))
      else $error("zero repeat count");

endmodule

bind line_printer_canonicalizer lpc_checker u_lpc_checker (.*);
`default_nettype wire
